// ===== hdl/cpth_pkg.sv =====
// Shared types and constants for the color period to HSL converter.
package cpth_pkg;

    localparam int PERIOD_BITS = 8;
    localparam int DEN_W       = 2 * PERIOD_BITS;
    localparam int NUM_W       = 2 * PERIOD_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int OFFSET_W    = 8;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd3;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] red_period;
        logic [PERIOD_BITS-1:0] green_period;
        logic [PERIOD_BITS-1:0] blue_period;
        logic [PERIOD_BITS-1:0] clear_period;
    } color_in_t;

    typedef struct packed {
        logic [11:0] hue_tenths;
        logic [9:0]  saturation_tenths;
        logic [9:0]  lightness_tenths;
    } color_out_t;

    // Classified request: per channel a saturate flag, the starting remainder and divisor.
    typedef struct packed {
        logic [2:0]            sat_one;
        logic [2:0][DEN_W-1:0] rem;
        logic [2:0][DEN_W-1:0] den;
    } cpth_work_t;

endpackage

// ===== hdl/cpth_front.sv =====
// Front end: holds the offset register, accepts requests and sets up channel divisions.
module cpth_front
    import cpth_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [OFFSET_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  color_in_t           s_data,
    output logic                work_valid,
    input  logic                work_ready,
    output cpth_work_t          work_data
);

    logic [OFFSET_W-1:0] offset_reg;
    logic                valid_reg;
    cpth_work_t          work_reg;
    cpth_work_t          work_next;

    assign s_ready    = !valid_reg || work_ready;
    assign work_valid = valid_reg;
    assign work_data  = work_reg;

    always_comb begin
        logic [PERIOD_BITS-1:0] ch;
        logic [PERIOD_BITS-1:0] clr;
        logic [NUM_W-1:0]       num;
        logic [DEN_W-1:0]       den;
        clr = s_data.clear_period;
        for (int i = 0; i < 3; i++) begin
            unique case (i)
                0:       ch = s_data.red_period;
                1:       ch = s_data.green_period;
                default: ch = s_data.blue_period;
            endcase
            num = NUM_W'(offset_reg) * NUM_W'(ch) + NUM_W'(clr) * NUM_W'(clr);
            den = DEN_W'(clr) * DEN_W'(ch);
            work_next.den[i]     = den;
            work_next.sat_one[i] = (clr == '0) || (ch == '0) || (num >= NUM_W'(den));
            // saturated channels need no remainder; num < den otherwise
            work_next.rem[i]     = work_next.sat_one[i] ? '0 : num[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) offset_reg <= cfg_wdata;
            if (s_ready) valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) work_reg <= work_next;
    end

endmodule

// ===== hdl/cpth_queue.sv =====
// Short request queue between the front end and the back end.
module cpth_queue
    import cpth_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  cpth_work_t wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output cpth_work_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cpth_work_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= PTR_W'((int'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            if (pop)  rd_ptr_reg <= PTR_W'((int'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/cpth_back.sv =====
// Back end: pipelined channel division, max/min HSL math and result dividers.
module cpth_back
    import cpth_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       work_valid,
    output logic       work_ready,
    input  cpth_work_t work_data,
    output logic       m_valid,
    input  logic       m_ready,
    output color_out_t m_data
);

    localparam int Q_W        = 16;
    localparam int CH_W       = Q_W + 1;
    localparam int SAT_QW     = 10;
    localparam int HUE_QW     = 13;
    localparam int SAT_NUM_W  = 30;
    localparam int SAT_DIV_W  = 19;
    localparam int HUE_NUM_W  = 32;
    localparam int HUE_DIV_W  = 18;
    localparam int CMP_W      = 33;
    localparam logic [CH_W-1:0] ONE_Q16 = CH_W'(1) << Q_W;
    localparam logic [HUE_QW-1:0] HUE_WRAP = HUE_QW'(3600);

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } hue_sel_t;

    logic en;
    logic valid_out_reg;
    color_out_t out_reg;

    // channel divider stages
    logic                  dv_reg   [Q_W];
    logic [2:0]            one_reg  [Q_W];
    logic [2:0][DEN_W-1:0] rem_reg  [Q_W];
    logic [2:0][DEN_W-1:0] den_reg  [Q_W];
    logic [2:0][Q_W-1:0]   q_reg    [Q_W];
    logic [2:0][DEN_W-1:0] rem_next [Q_W];
    logic [2:0][Q_W-1:0]   q_next   [Q_W];

    // max/min stage
    logic [CH_W-1:0]          m1_c [3];
    logic [CH_W-1:0]          m1_mx;
    logic [CH_W-1:0]          m1_mn;
    logic                     m1_valid_reg;
    logic [CH_W-1:0]          delta_reg;
    logic [CH_W:0]            sum_reg;
    logic signed [CH_W:0]     diff_reg;
    hue_sel_t                 sel_reg;

    // numerator setup stage
    logic [27:0]                 m2_lig_prod;
    logic [CH_W:0]               m2_dens;
    logic signed [HUE_NUM_W-1:0] m2_p;
    logic                     m2_valid_reg;
    logic [9:0]               lig_reg;
    logic                     grey_reg;
    logic [SAT_NUM_W-1:0]     sat_num_reg;
    logic [SAT_DIV_W-1:0]     sat_div_reg;
    logic [HUE_NUM_W-1:0]     hue_num_reg;
    logic [HUE_DIV_W-1:0]     hue_div_reg;

    // result divider stages
    logic                     hv_reg    [HUE_QW];
    logic [9:0]               hlig_reg  [HUE_QW];
    logic                     hgrey_reg [HUE_QW];
    logic [SAT_NUM_W-1:0]     srem_reg  [HUE_QW];
    logic [SAT_DIV_W-1:0]     sdiv_reg  [HUE_QW];
    logic [SAT_QW-1:0]        sq_reg    [HUE_QW];
    logic [HUE_NUM_W-1:0]     hrem_reg  [HUE_QW];
    logic [HUE_DIV_W-1:0]     hdiv_reg  [HUE_QW];
    logic [HUE_QW-1:0]        hq_reg    [HUE_QW];
    logic [SAT_NUM_W-1:0]     srem_next [HUE_QW];
    logic [SAT_QW-1:0]        sq_next   [HUE_QW];
    logic [HUE_NUM_W-1:0]     hrem_next [HUE_QW];
    logic [HUE_QW-1:0]        hq_next   [HUE_QW];

    assign en         = !valid_out_reg || m_ready;
    assign work_ready = en;
    assign m_valid    = valid_out_reg;
    assign m_data     = out_reg;

    // one restoring step per stage: shift the remainder, subtract the divisor if it fits
    always_comb begin
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] d;
        logic [Q_W-1:0]   qq;
        logic [DEN_W:0]   t;
        for (int k = 0; k < Q_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    r  = work_data.rem[i];
                    d  = work_data.den[i];
                    qq = '0;
                end else begin
                    r  = rem_reg[k-1][i];
                    d  = den_reg[k-1][i];
                    qq = q_reg[k-1][i];
                end
                t = {r, 1'b0};
                if (t >= {1'b0, d}) begin
                    rem_next[k][i] = DEN_W'(t - {1'b0, d});
                    q_next[k][i]   = {qq[Q_W-2:0], 1'b1};
                end else begin
                    rem_next[k][i] = t[DEN_W-1:0];
                    q_next[k][i]   = {qq[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Q_W; k++) dv_reg[k] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= work_valid;
            for (int k = 1; k < Q_W; k++) dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                if (k == 0) begin
                    den_reg[k] <= work_data.den;
                    one_reg[k] <= work_data.sat_one;
                end else begin
                    den_reg[k] <= den_reg[k-1];
                    one_reg[k] <= one_reg[k-1];
                end
            end
        end
    end

    // max/min with red over green over blue on ties
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1_c[i] = one_reg[Q_W-1][i] ? ONE_Q16 : {1'b0, q_reg[Q_W-1][i]};
        end
        m1_mx = m1_c[0];
        if (m1_c[1] > m1_mx) m1_mx = m1_c[1];
        if (m1_c[2] > m1_mx) m1_mx = m1_c[2];
        m1_mn = m1_c[0];
        if (m1_c[1] < m1_mn) m1_mn = m1_c[1];
        if (m1_c[2] < m1_mn) m1_mn = m1_c[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= dv_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta_reg <= m1_mx - m1_mn;
            sum_reg   <= {1'b0, m1_mx} + {1'b0, m1_mn};
            priority if (m1_c[0] == m1_mx) begin
                sel_reg  <= SEL_RED;
                diff_reg <= $signed({1'b0, m1_c[1]}) - $signed({1'b0, m1_c[2]});
            end else if (m1_c[1] == m1_mx) begin
                sel_reg  <= SEL_GREEN;
                diff_reg <= $signed({1'b0, m1_c[2]}) - $signed({1'b0, m1_c[0]});
            end else begin
                sel_reg  <= SEL_BLUE;
                diff_reg <= $signed({1'b0, m1_c[0]}) - $signed({1'b0, m1_c[1]});
            end
        end
    end

    // lightness, saturation and hue numerators; hue offset by a full turn to stay positive
    always_comb begin
        logic [HUE_NUM_W-1:0] base;
        m2_lig_prod = 28'(sum_reg) * 28'd1000 + 28'(ONE_Q16);
        m2_dens = (sum_reg < {1'b0, ONE_Q16}) ? sum_reg : ({ONE_Q16, 1'b0} - sum_reg);
        unique case (sel_reg)
            SEL_RED:   base = HUE_NUM_W'(delta_reg) * HUE_NUM_W'(3600);
            SEL_GREEN: base = HUE_NUM_W'(delta_reg) * HUE_NUM_W'(4800);
            default:   base = HUE_NUM_W'(delta_reg) * HUE_NUM_W'(6000);
        endcase
        m2_p = $signed(base) + HUE_NUM_W'(diff_reg) * HUE_NUM_W'(600);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lig_reg     <= m2_lig_prod[26:17];
            grey_reg    <= (delta_reg == '0);
            sat_num_reg <= SAT_NUM_W'(delta_reg) * SAT_NUM_W'(2000) + SAT_NUM_W'(m2_dens);
            sat_div_reg <= {m2_dens, 1'b0};
            hue_num_reg <= HUE_NUM_W'({m2_p[HUE_NUM_W-2:0], 1'b0}) + HUE_NUM_W'(delta_reg);
            hue_div_reg <= {delta_reg, 1'b0};
        end
    end

    // one quotient bit per stage, high bit first; saturation starts late, it has fewer bits
    always_comb begin
        logic [SAT_NUM_W-1:0] sr;
        logic [SAT_DIV_W-1:0] sd;
        logic [SAT_QW-1:0]    sq;
        logic [HUE_NUM_W-1:0] hr;
        logic [HUE_DIV_W-1:0] hd;
        logic [HUE_QW-1:0]    hq;
        logic [CMP_W-1:0]     sh;
        for (int j = 0; j < HUE_QW; j++) begin
            if (j == 0) begin
                sr = sat_num_reg; sd = sat_div_reg; sq = '0;
                hr = hue_num_reg; hd = hue_div_reg; hq = '0;
            end else begin
                sr = srem_reg[j-1]; sd = sdiv_reg[j-1]; sq = sq_reg[j-1];
                hr = hrem_reg[j-1]; hd = hdiv_reg[j-1]; hq = hq_reg[j-1];
            end
            sh = CMP_W'(hd) << (HUE_QW - 1 - j);
            if (CMP_W'(hr) >= sh) begin
                hrem_next[j] = HUE_NUM_W'(CMP_W'(hr) - sh);
                hq_next[j]   = hq | (HUE_QW'(1) << (HUE_QW - 1 - j));
            end else begin
                hrem_next[j] = hr;
                hq_next[j]   = hq;
            end
            srem_next[j] = sr;
            sq_next[j]   = sq;
            if (j >= HUE_QW - SAT_QW) begin
                sh = CMP_W'(sd) << (HUE_QW - 1 - j);
                if (CMP_W'(sr) >= sh) begin
                    srem_next[j] = SAT_NUM_W'(CMP_W'(sr) - sh);
                    sq_next[j]   = sq | (SAT_QW'(1) << (HUE_QW - 1 - j));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < HUE_QW; j++) hv_reg[j] <= 1'b0;
        end else if (en) begin
            hv_reg[0] <= m2_valid_reg;
            for (int j = 1; j < HUE_QW; j++) hv_reg[j] <= hv_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < HUE_QW; j++) begin
                srem_reg[j] <= srem_next[j];
                sq_reg[j]   <= sq_next[j];
                hrem_reg[j] <= hrem_next[j];
                hq_reg[j]   <= hq_next[j];
                if (j == 0) begin
                    sdiv_reg[j]  <= sat_div_reg;
                    hdiv_reg[j]  <= hue_div_reg;
                    hlig_reg[j]  <= lig_reg;
                    hgrey_reg[j] <= grey_reg;
                end else begin
                    sdiv_reg[j]  <= sdiv_reg[j-1];
                    hdiv_reg[j]  <= hdiv_reg[j-1];
                    hlig_reg[j]  <= hlig_reg[j-1];
                    hgrey_reg[j] <= hgrey_reg[j-1];
                end
            end
        end
    end

    // wrap hue past a full turn; force hue and saturation to zero on grey
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (en) begin
            valid_out_reg <= hv_reg[HUE_QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [HUE_QW-1:0] hq;
        hq = hq_reg[HUE_QW-1];
        if (en) begin
            out_reg.lightness_tenths <= hlig_reg[HUE_QW-1];
            if (hgrey_reg[HUE_QW-1]) begin
                out_reg.hue_tenths        <= '0;
                out_reg.saturation_tenths <= '0;
            end else begin
                out_reg.saturation_tenths <= sq_reg[HUE_QW-1];
                if (hq >= HUE_WRAP) out_reg.hue_tenths <= 12'(hq - HUE_WRAP);
                else                out_reg.hue_tenths <= hq[11:0];
            end
        end
    end

endmodule

// ===== hdl/color_period_to_hsl.sv =====
// Converts four color-sensor pulse periods to hue, saturation and lightness.
//
// Channels: s_valid/s_ready/s_data carry one request of red, green, blue and
// clear periods; m_valid/m_ready/m_data return one HSL result per request, in
// order. Both use valid/ready; a request moves when both are high.
// cfg_we/cfg_wdata write the luminosity offset (reset value 3) with no wait;
// write it only while no request is in flight.
// A request passes one front stage, one queue slot, 16 channel division steps,
// two setup stages, 13 result division steps and one output register on its
// way to the result.
// Throughput: one request per cycle; the bit-per-stage dividers are fully
// pipelined, so the rate is set by the handshakes alone.
// Reset clears all valid flags, empties the queue and restores the offset.
// When the receiver stalls the back pipeline holds; the four-entry queue and
// the front register keep taking requests until they fill, then s_ready drops.
module color_period_to_hsl
    import cpth_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [OFFSET_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  color_in_t           s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output color_out_t          m_data
);

    logic       fw_valid;
    logic       fw_ready;
    cpth_work_t fw_data;
    logic       bw_valid;
    logic       bw_ready;
    cpth_work_t bw_data;

    cpth_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .work_valid (fw_valid),
        .work_ready (fw_ready),
        .work_data  (fw_data)
    );

    cpth_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fw_valid),
        .wr_ready (fw_ready),
        .wr_data  (fw_data),
        .rd_valid (bw_valid),
        .rd_ready (bw_ready),
        .rd_data  (bw_data)
    );

    cpth_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .work_valid (bw_valid),
        .work_ready (bw_ready),
        .work_data  (bw_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
